// ===== src/descending_insertion_sorter_top_macros.svh =====
// Assertion macros for the descending insertion sorter.
// Needs i_clk and i_rst_n in the scope of the module that uses them.
`ifndef DESCENDING_INSERTION_SORTER_TOP_MACROS_SVH
`define DESCENDING_INSERTION_SORTER_TOP_MACROS_SVH

// same-cycle implication
`define DIS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DIS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dis_pkg.sv =====
// Package for the descending insertion sorter: sizes, codes, payload and state types.
// No dependencies.
`timescale 1ns / 1ps

package dis_pkg;

    localparam int DEPTH = 32;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int VW    = 32;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_PRINT = 1'b1;

    localparam logic ST_VALUE = 1'b0;
    localparam logic ST_DROP  = 1'b1;

    typedef struct packed {
        logic                 op;
        logic signed [VW-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [VW-1:0] sorted_value;
        logic                 last;
        logic                 status;
    } t_out;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_KEY   = 6'b000010,
        S_CMP   = 6'b000100,
        S_PLACE = 6'b001000,
        S_ERD   = 6'b010000,
        S_EOUT  = 6'b100000
    } t_state;

endpackage

// ===== src/dis_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/descending_insertion_sorter_top.sv =====
// Add: no result unless the store is full (one drop status transfer).
// Print: insertion sort in place in the value RAM, which has a single read and a single write
// port; then the values are emitted, largest first.
// Reset clears the count and the control state; the RAM is not cleared.
`timescale 1ns / 1ps
`include "descending_insertion_sorter_top_macros.svh"

module descending_insertion_sorter_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  dis_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output dis_pkg::t_out o_out
);

    dis_pkg::t_state r_state, n_state;
    logic [dis_pkg::CW-1:0] r_count, n_count;
    logic [dis_pkg::AW-1:0] r_i, n_i;
    logic [dis_pkg::AW-1:0] r_pos, n_pos;
    logic [dis_pkg::AW-1:0] r_k, n_k;
    logic signed [dis_pkg::VW-1:0] r_key, n_key;
    logic          r_out_valid;
    dis_pkg::t_out r_out;

    logic                   ram_we;
    logic [dis_pkg::AW-1:0] ram_waddr;
    logic [dis_pkg::VW-1:0] ram_wdata;
    logic                   ram_re;
    logic [dis_pkg::AW-1:0] ram_raddr;
    logic [dis_pkg::VW-1:0] ram_rdata;

    logic          out_free;
    logic          in_fire;
    logic          out_load;
    dis_pkg::t_out out_data;
    logic          do_finish;
    logic [dis_pkg::AW-1:0] finish_addr;
    logic          emit_last;

    dis_ram #(
        .WIDTH (dis_pkg::VW),
        .DEPTH (dis_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != dis_pkg::S_IDLE) || !out_free;
    assign in_fire    = i_in_valid && !o_in_stall;
    assign emit_last  = ((dis_pkg::CW'(r_k) + dis_pkg::CW'(1)) == r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_i         = r_i;
        n_pos       = r_pos;
        n_k         = r_k;
        n_key       = r_key;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        out_load    = 1'b0;
        out_data    = '0;
        do_finish   = 1'b0;
        finish_addr = '0;
        case (r_state)
            dis_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (i_in.op == dis_pkg::OP_ADD) begin
                        if (r_count == dis_pkg::CW'(dis_pkg::DEPTH)) begin
                            out_load              = 1'b1;
                            out_data.sorted_value = '0;
                            out_data.last         = 1'b1;
                            out_data.status       = dis_pkg::ST_DROP;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_count[dis_pkg::AW-1:0];
                            ram_wdata = i_in.value;
                            n_count   = r_count + dis_pkg::CW'(1);
                        end
                    end else if (r_count > dis_pkg::CW'(1)) begin
                        ram_re    = 1'b1;
                        ram_raddr = dis_pkg::AW'(1);
                        n_i       = dis_pkg::AW'(1);
                        n_state   = dis_pkg::S_KEY;
                    end else if (r_count == dis_pkg::CW'(1)) begin
                        n_k     = '0;
                        n_state = dis_pkg::S_ERD;
                    end
                end
            end
            dis_pkg::S_KEY: begin
                n_key     = ram_rdata;
                n_pos     = r_i;
                ram_re    = 1'b1;
                ram_raddr = r_i - dis_pkg::AW'(1);
                n_state   = dis_pkg::S_CMP;
            end
            dis_pkg::S_CMP: begin
                if ($signed(ram_rdata) < r_key) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pos;
                    ram_wdata = ram_rdata;
                    n_pos     = r_pos - dis_pkg::AW'(1);
                    if (r_pos != dis_pkg::AW'(1)) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_pos - dis_pkg::AW'(2);
                    end else begin
                        n_state = dis_pkg::S_PLACE;
                    end
                end else begin
                    do_finish   = 1'b1;
                    finish_addr = r_pos;
                end
            end
            dis_pkg::S_PLACE: begin
                do_finish   = 1'b1;
                finish_addr = '0;
            end
            dis_pkg::S_ERD: begin
                ram_re    = 1'b1;
                ram_raddr = r_k;
                n_state   = dis_pkg::S_EOUT;
            end
            dis_pkg::S_EOUT: begin
                if (out_free) begin
                    out_load              = 1'b1;
                    out_data.sorted_value = ram_rdata;
                    out_data.last         = emit_last;
                    out_data.status       = dis_pkg::ST_VALUE;
                    if (emit_last) begin
                        n_state = dis_pkg::S_IDLE;
                    end else begin
                        n_k     = r_k + dis_pkg::AW'(1);
                        n_state = dis_pkg::S_ERD;
                    end
                end
            end
            default: begin
                n_state = dis_pkg::S_IDLE;
            end
        endcase

        // key lands; move on to the next key or start the emit run
        if (do_finish) begin
            ram_we    = 1'b1;
            ram_waddr = finish_addr;
            ram_wdata = r_key;
            if ((dis_pkg::CW'(r_i) + dis_pkg::CW'(1)) < r_count) begin
                n_i       = r_i + dis_pkg::AW'(1);
                ram_re    = 1'b1;
                ram_raddr = r_i + dis_pkg::AW'(1);
                n_state   = dis_pkg::S_KEY;
            end else begin
                n_k     = '0;
                n_state = dis_pkg::S_ERD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dis_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i   <= n_i;
        r_pos <= n_pos;
        r_k   <= n_k;
        r_key <= n_key;
        if (out_load) begin
            r_out <= out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `DIS_ASSERT_IMP(a_no_rw_collide, ram_we && ram_re, ram_waddr != ram_raddr, "RAM read and write hit the same entry")
    `DIS_ASSERT_IMP(a_cmp_pos_nonzero, r_state == dis_pkg::S_CMP, r_pos != '0, "compare step with insert position zero")
    `DIS_ASSERT_IMP(a_count_bound, 1'b1, r_count <= dis_pkg::CW'(dis_pkg::DEPTH), "count exceeds depth")
    `DIS_ASSERT_IMP(a_drop_when_full, o_out_valid && (o_out.status == dis_pkg::ST_DROP), r_count == dis_pkg::CW'(dis_pkg::DEPTH), "drop status with room in the store")
    `DIS_ASSERT_NXT(a_emit_keeps_count, r_state == dis_pkg::S_EOUT, $stable(r_count), "count changed during emit")

endmodule

// ===== tb/sv/tb_descending_insertion_sorter_top.sv =====
// Self-checking testbench for descending_insertion_sorter_top: adds, drops on a full store,
// sorted prints. Drives random valid/stall traffic and checks each result against a model.
// Depends on dis_pkg and the sorter RTL.
`timescale 1ns / 1ps

module tb_descending_insertion_sorter_top;

    localparam int QUIET_LIMIT = 5000;
    localparam int N_RANDOM    = 92;

    class sorter_scoreboard;
        dis_pkg::t_out                 pending[$];
        logic signed [dis_pkg::VW-1:0] store[$];
        int                            errors = 0;

        function void note_input(dis_pkg::t_in item);
            logic signed [dis_pkg::VW-1:0] key;
            int                            pos;
            dis_pkg::t_out                 res;
            if (item.op == dis_pkg::OP_ADD) begin
                if (store.size() >= dis_pkg::DEPTH) begin
                    res.sorted_value = '0;
                    res.last         = 1'b1;
                    res.status       = dis_pkg::ST_DROP;
                    pending.push_back(res);
                end else begin
                    store.push_back(item.value);
                end
            end else begin
                // stable insertion sort, largest first
                for (int i = 1; i < store.size(); i++) begin
                    key = store[i];
                    pos = i;
                    while (pos > 0 && store[pos-1] < key) begin
                        store[pos] = store[pos-1];
                        pos--;
                    end
                    store[pos] = key;
                end
                for (int k = 0; k < store.size(); k++) begin
                    res.sorted_value = store[k];
                    res.last         = (k == store.size() - 1);
                    res.status       = dis_pkg::ST_VALUE;
                    pending.push_back(res);
                end
            end
        endfunction

        function void check_result(dis_pkg::t_out got);
            dis_pkg::t_out want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result value=%0d last=%0b status=%0b",
                         $time, got.sorted_value, got.last, got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.sorted_value !== want.sorted_value) begin
                $display("%0t: sorted_value expected %0d actual %0d",
                         $time, want.sorted_value, got.sorted_value);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0b actual %0b", $time, want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic          i_out_stall = 1'b0;
    dis_pkg::t_in  i_in        = '0;
    logic          o_in_stall;
    logic          o_out_valid;
    dis_pkg::t_out o_out;

    logic idle_on = 1'b1;
    int   quiet_cycles = 0;
    logic in_xfer;
    logic out_xfer;

    sorter_scoreboard sb = new;

    descending_insertion_sorter_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #2 i_clk = ~i_clk;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;

    always @(posedge i_clk) begin
        i_out_stall <= idle_on && ($urandom_range(99) < 18);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_xfer) begin
                sb.note_input(i_in);
            end
            if (out_xfer) begin
                sb.check_result(o_out);
            end
            if (in_xfer || out_xfer) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send(input logic op, input logic signed [dis_pkg::VW-1:0] v);
        dis_pkg::t_in item;
        item.op    = op;
        item.value = v;
        while (idle_on && $urandom_range(99) < 18) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // wait on the clock first so the last transfer is already in the scoreboard
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [dis_pkg::VW-1:0] rand_value();
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(4))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return 32'sh0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            1: return int'($urandom_range(8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty print, single value, extremes, duplicates, ignored print payload
        send(dis_pkg::OP_PRINT, 32'sh0);
        send(dis_pkg::OP_ADD,   32'sd42);
        send(dis_pkg::OP_PRINT, -32'sd1);
        send(dis_pkg::OP_ADD,   32'sh7fffffff);
        send(dis_pkg::OP_ADD,   32'sh80000000);
        send(dis_pkg::OP_ADD,   32'sh0);
        send(dis_pkg::OP_ADD,   -32'sd1);
        send(dis_pkg::OP_ADD,   32'sd1);
        send(dis_pkg::OP_ADD,   32'sd5);
        send(dis_pkg::OP_ADD,   32'sd5);
        send(dis_pkg::OP_ADD,   -32'sd5);
        send(dis_pkg::OP_PRINT, 32'shdeadbeef);
        wait_drained();
        send(dis_pkg::OP_ADD,   32'sh80000000);
        send(dis_pkg::OP_ADD,   32'sh7fffffff);
        send(dis_pkg::OP_PRINT, 32'sh7fffffff);

        for (int n = 0; n < N_RANDOM; n++) begin
            idle_on = !(n >= 40 && n < 75);
            if (n == 90) begin
                wait_drained();
            end
            if ($urandom_range(99) < 70) begin
                send(dis_pkg::OP_ADD, rand_value());
            end else begin
                send(dis_pkg::OP_PRINT, $urandom);
            end
        end
        idle_on = 1'b1;
        // store is full by now: one last drop and one full-depth print
        send(dis_pkg::OP_ADD, rand_value());
        send(dis_pkg::OP_PRINT, $urandom);

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
